// ===== rtl/core/cpp_pkg.sv =====
`default_nettype none
package cpp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VEC_W         = 63;
  localparam int CFG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int COMP_W        = 21;
  localparam int NUM_W         = 48;
  localparam int DEN_W         = 64;
  localparam int DOT_SHIFT     = 18;

  localparam logic [VEC_W-1:0] RIGHT_RESET  = 63'd262144;
  localparam logic [VEC_W-1:0] UP_RESET     = 63'd549755813888;
  localparam logic [VEC_W-1:0] FWD_RESET    = 63'd1152921504606846976;
  localparam logic [63:0]      FOV_RESET    = 64'h0001_0001_0001_0001;
  localparam logic [31:0]      SCREEN_RESET = 32'd70780800;

  typedef enum logic [IDX_W-1:0] {
    REG_RIGHT  = 3'd0,
    REG_UP     = 3'd1,
    REG_FWD    = 3'd2,
    REG_CAM_XY = 3'd3,
    REG_CAM_Z  = 3'd4,
    REG_FOV    = 3'd5,
    REG_SCREEN = 3'd6
  } cpp_reg_t;

  typedef struct packed {
    logic neg_x;
    logic zero_x;
    logic zero_y;
    logic z_ge_one;
    logic clip;
  } cpp_side_t;

  function automatic logic signed [COMP_W:0] axis_comp(input logic [VEC_W-1:0] vec,
                                                       input int idx, input logic neg);
    logic [COMP_W-1:0] raw;
    logic signed [COMP_W:0] c;
    raw = vec[idx*COMP_W +: COMP_W];
    c = signed'({raw[COMP_W-1], raw});
    return neg ? -c : c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cpp_transform.sv =====
`default_nettype none
module cpp_transform import cpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] world_x,
  input  wire logic signed [31:0] world_y,
  input  wire logic signed [31:0] world_z,
  input  wire logic [VEC_W-1:0]   right_vector,
  input  wire logic [VEC_W-1:0]   up_vector,
  input  wire logic [VEC_W-1:0]   forward_vector,
  input  wire logic [63:0]        camera_xy,
  input  wire logic [31:0]        camera_z,
  input  wire logic [63:0]        fov_scales,
  input  wire logic [31:0]        screen_size,
  output logic                    out_valid,
  output logic [NUM_W-1:0]        num_x,
  output logic [DEN_W-1:0]        den_x,
  output logic [NUM_W-1:0]        num_y,
  output logic [DEN_W-1:0]        den_y,
  output logic                    neg_y,
  output cpp_side_t               side
);

  localparam int PROD_W = 33 + COMP_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic v1, v2, v3;
  logic signed [32:0] dv [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [31:0] axis [3];
  logic clip3;

  logic [VEC_W-1:0] vecs [3];
  logic signed [31:0] axis_next [3];
  logic clip_next;

  assign vecs[0] = right_vector;
  assign vecs[1] = up_vector;
  assign vecs[2] = forward_vector;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= signed'({world_x[31], world_x}) - signed'({camera_xy[31], camera_xy[31:0]});
      dv[1] <= signed'({world_y[31], world_y}) - signed'({camera_xy[63], camera_xy[63:32]});
      dv[2] <= signed'({world_z[31], world_z}) - signed'({camera_z[31], camera_z});
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= PROD_W'(dv[k]) * PROD_W'(axis_comp(vecs[a], k, a == 2));
        end
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sh;
    logic ovf;
    clip_next = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sum = SUM_W'(prod[a][0]) + SUM_W'(prod[a][1]) + SUM_W'(prod[a][2]);
      sh = sum >>> DOT_SHIFT;
      ovf = !((&sh[SUM_W-1:31]) || !(|sh[SUM_W-1:31]));
      if (ovf) begin
        axis_next[a] = sh[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        clip_next = 1'b1;
      end else begin
        axis_next[a] = sh[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis <= axis_next;
      clip3 <= clip_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] ax, ay, az;
    ax = axis[0][31] ? 32'(-axis[0]) : axis[0];
    ay = axis[1][31] ? 32'(-axis[1]) : axis[1];
    az = axis[2][31] ? 32'(-axis[2]) : axis[2];
    if (en) begin
      num_x <= NUM_W'(screen_size[15:0]) * NUM_W'(ax);
      num_y <= NUM_W'(screen_size[31:16]) * NUM_W'(ay);
      den_x <= DEN_W'(fov_scales[31:0]) * DEN_W'(az);
      den_y <= DEN_W'(fov_scales[63:32]) * DEN_W'(az);
      neg_y <= axis[1][31] ^ axis[2][31];
      side.neg_x <= ~(axis[0][31] ^ axis[2][31]);
      side.zero_x <= (axis[2] == 32'sd0) || (fov_scales[31:0] == 32'd0);
      side.zero_y <= (axis[2] == 32'sd0) || (fov_scales[63:32] == 32'd0);
      side.z_ge_one <= !axis[2][31] && (axis[2] >= (32'sd1 <<< FRAC_BITS));
      side.clip <= clip3;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpp_divider.sv =====
`default_nettype none
module cpp_divider import cpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TAG_W     = 1,
  localparam int DW       = NUM_W + 2 * FRAC_BITS - 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [TAG_W-1:0] tag_in,
  output logic                  out_valid,
  output logic [DW-1:0]         quo,
  output logic [TAG_W-1:0]      tag_out
);

  logic             v    [DW+1];
  logic [DEN_W-1:0] rem  [DW+1];
  logic [DEN_W-1:0] dens [DW+1];
  logic [DW-1:0]    nums [DW+1];
  logic [DW-1:0]    quos [DW+1];
  logic [TAG_W-1:0] tags [DW+1];

  logic [DEN_W-1:0] rem_next [DW];
  logic [DW-1:0]    quo_next [DW];

  always_comb begin
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic ge;
    for (int i = 0; i < DW; i++) begin
      t = {rem[i], nums[i][DW-1]};
      diff = t - {1'b0, dens[i]};
      ge = t >= {1'b0, dens[i]};
      rem_next[i] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      quo_next[i] = {quos[i][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DW; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 0; i < DW; i++) begin
        v[i+1] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      dens[0] <= den;
      nums[0] <= {num, {(2 * FRAC_BITS - 1){1'b0}}};
      quos[0] <= '0;
      tags[0] <= tag_in;
      for (int i = 0; i < DW; i++) begin
        rem[i+1]  <= rem_next[i];
        dens[i+1] <= dens[i];
        nums[i+1] <= {nums[i][DW-2:0], 1'b0};
        quos[i+1] <= quo_next[i];
        tags[i+1] <= tags[i];
      end
    end
  end

  assign out_valid = v[DW];
  assign quo       = quos[DW];
  assign tag_out   = tags[DW];

endmodule
`default_nettype wire

// ===== rtl/core/camera_perspective_projection.sv =====
`default_nettype none
// Pipeline from accepted input word to output word: four transform stages, a restoring divider
//   of 2*FRAC_BITS + 47 one-bit stages plus its input register, and the output register.
// Throughput: one word per cycle; the whole pipeline holds while an output word is stalled.
// Reset: synchronous; clears all valid bits and loads the camera registers with their defaults.
module camera_perspective_projection import cpp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_index,
  input  wire logic [CFG_W-1:0]   wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] world_x,
  input  wire logic signed [31:0] world_y,
  input  wire logic signed [31:0] world_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      screen_x,
  output logic signed [31:0]      screen_y,
  output logic                    on_screen,
  output logic                    clipped
);

  localparam int DW   = NUM_W + 2 * FRAC_BITS - 1;
  localparam int QE_W = DW + 64;
  localparam int TW   = $bits(cpp_side_t);

  logic [VEC_W-1:0] right_vector, up_vector, forward_vector;
  logic [63:0] camera_xy, fov_scales;
  logic [31:0] camera_z, screen_size;

  logic en;
  logic t_valid, t_neg_y;
  logic [NUM_W-1:0] num_x, num_y;
  logic [DEN_W-1:0] den_x, den_y;
  cpp_side_t t_side, d_side;
  logic [TW-1:0] d_tag;
  logic dx_valid, dy_valid, d_neg_y;
  logic [DW-1:0] qx, qy;
  logic signed [63:0] rx, ry;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_vector   <= RIGHT_RESET;
      up_vector      <= UP_RESET;
      forward_vector <= FWD_RESET;
      camera_xy      <= '0;
      camera_z       <= '0;
      fov_scales     <= FOV_RESET;
      screen_size    <= SCREEN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RIGHT:  right_vector   <= wr_data[VEC_W-1:0];
        REG_UP:     up_vector      <= wr_data[VEC_W-1:0];
        REG_FWD:    forward_vector <= wr_data[VEC_W-1:0];
        REG_CAM_XY: camera_xy      <= wr_data;
        REG_CAM_Z:  camera_z       <= wr_data[31:0];
        REG_FOV:    fov_scales     <= wr_data;
        REG_SCREEN: screen_size    <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  cpp_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
    .clk, .rst, .en, .in_valid, .world_x, .world_y, .world_z,
    .right_vector, .up_vector, .forward_vector, .camera_xy, .camera_z,
    .fov_scales, .screen_size,
    .out_valid(t_valid), .num_x, .den_x, .num_y, .den_y,
    .neg_y(t_neg_y), .side(t_side)
  );

  cpp_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(TW)) u_div_x (
    .clk, .rst, .en, .in_valid(t_valid), .num(num_x), .den(den_x),
    .tag_in(t_side), .out_valid(dx_valid), .quo(qx), .tag_out(d_tag)
  );

  cpp_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_y (
    .clk, .rst, .en, .in_valid(t_valid), .num(num_y), .den(den_y),
    .tag_in(t_neg_y), .out_valid(dy_valid), .quo(qy), .tag_out(d_neg_y)
  );

  assign d_side = d_tag;

  function automatic logic signed [63:0] place(input logic [DW-1:0] q,
                                               input logic [15:0] size, input logic neg);
    logic [QE_W-1:0] qe;
    logic over;
    logic [62:0] mag;
    logic signed [63:0] sq;
    qe = QE_W'(q);
    over = (|qe[QE_W-1:63]) || (qe[62] && (|qe[61:0]));
    mag = over ? {1'b1, 62'd0} : qe[62:0];
    sq = signed'({1'b0, mag});
    if (neg) begin
      sq = -sq;
    end
    return signed'(64'(size) << (FRAC_BITS - 1)) + sq;
  endfunction

  assign rx = place(qx, screen_size[15:0], d_side.neg_x);
  assign ry = place(qy, screen_size[31:16], d_neg_y);

  always_ff @(posedge clk) begin
    logic sat_x, sat_y;
    sat_x = !((&rx[63:31]) || !(|rx[63:31]));
    sat_y = !((&ry[63:31]) || !(|ry[63:31]));
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dx_valid;
    end
    if (en) begin
      if (d_side.zero_x) begin
        screen_x <= 32'sd0;
      end else if (sat_x) begin
        screen_x <= rx[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        screen_x <= rx[31:0];
      end
      if (d_side.zero_y) begin
        screen_y <= 32'sd0;
      end else if (sat_y) begin
        screen_y <= ry[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        screen_y <= ry[31:0];
      end
      on_screen <= !d_side.zero_x && !d_side.zero_y && !rx[63] && d_side.z_ge_one &&
                   (rx <= signed'(64'(screen_size[15:0]) << FRAC_BITS));
      clipped <= d_side.clip || d_side.zero_x || d_side.zero_y ||
                 (!d_side.zero_x && sat_x) || (!d_side.zero_y && sat_y);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) dx_valid == dy_valid)
    else $error("divider lanes out of step");

  a_on_screen_pos: assert property (@(posedge clk) disable iff (rst)
      out_valid && on_screen |-> !screen_x[31] && !clipped || !screen_x[31])
    else $error("on-screen word with negative x");

endmodule
`default_nettype wire
